[hw/rtl/aavr_pkg.sv]
// Package for the axis-angle vector rotation block: default widths, fixed-point
// constants and the divisor tables of the sine and cosine series.
// No dependencies.
`default_nettype none

package aavr_pkg;

   // Default widths of the payload fields.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int AXIS_WIDTH_DEF  = 16;
   localparam int ANGLE_WIDTH_DEF = 16;

   // Internal phase is 32 bits; Q30 fixed point for the trigonometry.
   localparam int PHASE_WIDTH = 32;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Low part of each coordinate in the split multiply.
   localparam int SPLIT_BITS = 24;

   // Series evaluation: five steps of three register stages each.
   localparam int NUM_STEPS = 5;

   // Register stages of the trigonometry unit, from the input transfer to sine and cosine.
   localparam int TRIG_LAT = 3 + 3 * NUM_STEPS + 1;

   // Divisors of the series steps. The sine series has four steps; its fifth slot
   // is taken by the final multiplication by the reduced angle.
   localparam logic [6:0] COS_DIV [NUM_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
   localparam logic [6:0] SIN_DIV [NUM_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6, 7'd1};

   // Reciprocals floor(2^32 / k) for the divide-by-constant steps.
   localparam logic [31:0] COS_RECIP [NUM_STEPS] = '{
      32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd2)};
   localparam logic [31:0] SIN_RECIP [NUM_STEPS] = '{
      32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
      32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6),
      32'd0};

endpackage

`default_nettype wire

[hw/rtl/aavr_trig.sv]
// Pipelined sine and cosine of a binary angle, Q30 results.
// Depends on aavr_pkg for the series constants and the stage count.
`default_nettype none

module aavr_trig #(
   parameter int ANGLE_WIDTH = aavr_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [ANGLE_WIDTH-1:0]        angle,
   output logic signed [31:0]                 sin_out,
   output logic signed [31:0]                 cos_out
);
   import aavr_pkg::*;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        swap;
   } trig_side_type;

   // Quadrant reduction.
   logic [PHASE_WIDTH-1:0] phase;
   logic [29:0]            frac;
   logic                   swap_in;
   logic [29:0]            g_in, g_ff;
   logic [1:0]             quad0_ff;
   logic                   swap0_ff;

   always_comb begin
      phase   = PHASE_WIDTH'(angle) << (PHASE_WIDTH - ANGLE_WIDTH);
      frac    = phase[29:0];
      swap_in = frac > 30'h2000_0000;
      g_in    = swap_in ? 30'(31'h4000_0000 - {1'b0, frac}) : frac;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         g_ff     <= g_in;
         quad0_ff <= phase[31:30];
         swap0_ff <= swap_in;
      end
   end

   // Conversion to radians.
   logic [60:0] x_prod;
   logic [29:0] x_in, x1_ff;
   logic [1:0]  quad1_ff;
   logic        swap1_ff;

   always_comb begin
      x_prod = 61'(g_ff) * 61'(HALF_PI_Q30);
      x_in   = 30'((x_prod + 61'h2000_0000) >> 30);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff    <= x_in;
         quad1_ff <= quad0_ff;
         swap1_ff <= swap0_ff;
      end
   end

   // Square of the reduced angle.
   logic [59:0]   x2_prod;
   trig_side_type side2_in, side2_ff;

   always_comb begin
      x2_prod       = 60'(x1_ff) * 60'(x1_ff);
      side2_in.x    = x1_ff;
      side2_in.x2   = 30'((x2_prod + 60'h2000_0000) >> 30);
      side2_in.quad = quad1_ff;
      side2_in.swap = swap1_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side2_ff <= side2_in;
      end
   end

   // Series steps: product, reciprocal multiply, then remainder correction.
   trig_side_type side_a_ff [NUM_STEPS];
   trig_side_type side_b_ff [NUM_STEPS];
   trig_side_type side_c_ff [NUM_STEPS];
   logic [30:0]   ua_c_ff [NUM_STEPS];
   logic [30:0]   ua_s_ff [NUM_STEPS];
   logic [30:0]   ub_c_ff [NUM_STEPS];
   logic [30:0]   ub_s_ff [NUM_STEPS];
   logic [30:0]   qb_c_ff [NUM_STEPS];
   logic [30:0]   qb_s_ff [NUM_STEPS];
   logic [30:0]   tc_ff   [NUM_STEPS];
   logic [30:0]   ts_ff   [NUM_STEPS];

   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
      trig_side_type side_src;
      logic [30:0]   tc_src, ts_src;
      logic [61:0]   pa_c, pa_s;
      logic [30:0]   ua_c_in, ua_s_in;
      logic [62:0]   pb_c, pb_s;
      logic [31:0]   rem_c, rem_s;
      logic [30:0]   tc_in, ts_in;

      if (i == 0) begin : g_first
         assign side_src = side2_ff;
         assign tc_src   = Q30_ONE;
         assign ts_src   = Q30_ONE;
      end else begin : g_next
         assign side_src = side_c_ff[i-1];
         assign tc_src   = tc_ff[i-1];
         assign ts_src   = ts_ff[i-1];
      end

      // Product of the running term with the squared angle (for the sine, with the angle at the last step).
      always_comb begin
         pa_c    = 62'(side_src.x2) * 62'(tc_src);
         ua_c_in = 31'((pa_c + 62'h2000_0000) >> 30);
         if (i == NUM_STEPS - 1) begin
            pa_s = 62'(side_src.x) * 62'(ts_src);
         end else begin
            pa_s = 62'(side_src.x2) * 62'(ts_src);
         end
         ua_s_in = 31'((pa_s + 62'h2000_0000) >> 30);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_a_ff[i] <= side_src;
            ua_c_ff[i]   <= ua_c_in;
            ua_s_ff[i]   <= ua_s_in;
         end
      end

      // Quotient estimate by reciprocal; it is at most one below the true quotient.
      always_comb begin
         pb_c = 63'(ua_c_ff[i]) * 63'(COS_RECIP[i]);
         pb_s = 63'(ua_s_ff[i]) * 63'(SIN_RECIP[i]);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_b_ff[i] <= side_a_ff[i];
            ub_c_ff[i]   <= ua_c_ff[i];
            ub_s_ff[i]   <= ua_s_ff[i];
            qb_c_ff[i]   <= pb_c[62:32];
            qb_s_ff[i]   <= pb_s[62:32];
         end
      end

      // Remainder correction and the new running term.
      always_comb begin
         rem_c = 32'(ub_c_ff[i]) - 32'(qb_c_ff[i]) * 32'(COS_DIV[i]);
         tc_in = Q30_ONE - (qb_c_ff[i] + 31'(rem_c >= 32'(COS_DIV[i])));
         rem_s = 32'(ub_s_ff[i]) - 32'(qb_s_ff[i]) * 32'(SIN_DIV[i]);
         if (i == NUM_STEPS - 1) begin
            ts_in = ub_s_ff[i];
         end else begin
            ts_in = Q30_ONE - (qb_s_ff[i] + 31'(rem_s >= 32'(SIN_DIV[i])));
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_c_ff[i] <= side_b_ff[i];
            tc_ff[i]     <= tc_in;
            ts_ff[i]     <= ts_in;
         end
      end
   end

   // Undo the octant swap and map the quadrant.
   logic signed [31:0] s2, c2, sin_in, cos_in, sin_ff, cos_ff;

   always_comb begin
      if (side_c_ff[NUM_STEPS-1].swap) begin
         s2 = signed'(32'(tc_ff[NUM_STEPS-1]));
         c2 = signed'(32'(ts_ff[NUM_STEPS-1]));
      end else begin
         s2 = signed'(32'(ts_ff[NUM_STEPS-1]));
         c2 = signed'(32'(tc_ff[NUM_STEPS-1]));
      end
      case (side_c_ff[NUM_STEPS-1].quad)
         2'd0: begin
            sin_in = s2;
            cos_in = c2;
         end
         2'd1: begin
            sin_in = c2;
            cos_in = -s2;
         end
         2'd2: begin
            sin_in = -s2;
            cos_in = -c2;
         end
         default: begin
            sin_in = -c2;
            cos_in = s2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

[hw/rtl/axis_angle_vector_rotation.sv]
// Rotates a Q16.16 vector about a Q1.14 unit axis by a binary angle using the
// Rodrigues formula, with round-half-up arithmetic and saturated results. One
// transfer is accepted every clock cycle unless rsp_stall holds the pipeline;
// each request passes through 19 register stages of sine and cosine and six
// of matrix build and matrix-vector multiply, and waits there under rsp_stall.
// The axis is used as given: a non-unit axis gives no true rotation, and a
// zero axis gives cos times the vector. Depends on aavr_pkg and aavr_trig.
`default_nettype none

module axis_angle_vector_rotation #(
   parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = aavr_pkg::AXIS_WIDTH_DEF,
   parameter int ANGLE_WIDTH = aavr_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_vec_z,
   input  wire logic signed [AXIS_WIDTH-1:0]  req_axis_x,
   input  wire logic signed [AXIS_WIDTH-1:0]  req_axis_y,
   input  wire logic signed [AXIS_WIDTH-1:0]  req_axis_z,
   input  wire logic [ANGLE_WIDTH-1:0]        req_turn_angle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_rot_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_rot_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_rot_z
);
   import aavr_pkg::*;

   localparam int NUM_STAGES = TRIG_LAT + 6;
   localparam int AXIS_DEPTH = TRIG_LAT;
   localparam int VEC_DEPTH  = TRIG_LAT + 3;
   localparam int VX_W       = (COORD_WIDTH > SPLIT_BITS) ? COORD_WIDTH : SPLIT_BITS + 1;
   localparam int VH_W       = VX_W - SPLIT_BITS;
   localparam int MW         = 36;
   localparam int PL_W       = MW + SPLIT_BITS + 1;
   localparam int PH_W       = MW + VH_W;
   localparam int SL_W       = PL_W + 2;
   localparam int SH_W       = PH_W + 2;
   localparam int SW         = SH_W + SPLIT_BITS + 2;
   localparam int RW         = SW - 30;

   // Pipeline advance: blocked only while a finished result waits.
   logic enable;
   logic [NUM_STAGES-1:0] vld_ff;

   assign enable    = !vld_ff[NUM_STAGES-1] || !rsp_stall;
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // Sine and cosine of the angle.
   logic signed [31:0] sn, cs;

   aavr_trig #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_trig (
      .clock   (clock),
      .enable  (enable),
      .angle   (req_turn_angle),
      .sin_out (sn),
      .cos_out (cs)
   );

   // Axis and vector travel alongside the trigonometry.
   logic signed [AXIS_WIDTH-1:0]  axis_d_ff [AXIS_DEPTH][3];
   logic signed [COORD_WIDTH-1:0] vec_d_ff  [VEC_DEPTH][3];

   always_ff @(posedge clock) begin
      if (enable) begin
         axis_d_ff[0][0] <= req_axis_x;
         axis_d_ff[0][1] <= req_axis_y;
         axis_d_ff[0][2] <= req_axis_z;
         vec_d_ff[0][0]  <= req_vec_x;
         vec_d_ff[0][1]  <= req_vec_y;
         vec_d_ff[0][2]  <= req_vec_z;
         for (int k = 1; k < AXIS_DEPTH; k++) begin
            axis_d_ff[k] <= axis_d_ff[k-1];
         end
         for (int k = 1; k < VEC_DEPTH; k++) begin
            vec_d_ff[k] <= vec_d_ff[k-1];
         end
      end
   end

   // Axis products, axis times sine and one minus cosine.
   logic signed [31:0] n [3];
   logic signed [63:0] nn_prod [6];
   logic signed [63:0] ns_prod [3];
   logic signed [31:0] nn_in [6];
   logic signed [31:0] nn_ff [6];
   logic signed [33:0] ns_in [3];
   logic signed [33:0] ns_ff [3];
   logic signed [32:0] omc_ff;
   logic signed [31:0] cs0_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n[i] = signed'(32'(axis_d_ff[AXIS_DEPTH-1][i]) << (32 - AXIS_WIDTH));
      end
      // Order: xx, yy, zz, xy, xz, yz.
      nn_prod[0] = 64'(n[0]) * 64'(n[0]);
      nn_prod[1] = 64'(n[1]) * 64'(n[1]);
      nn_prod[2] = 64'(n[2]) * 64'(n[2]);
      nn_prod[3] = 64'(n[0]) * 64'(n[1]);
      nn_prod[4] = 64'(n[0]) * 64'(n[2]);
      nn_prod[5] = 64'(n[1]) * 64'(n[2]);
      for (int i = 0; i < 6; i++) begin
         nn_in[i] = 32'((nn_prod[i] + 64'sh8000_0000) >>> 32);
      end
      for (int i = 0; i < 3; i++) begin
         ns_prod[i] = 64'(n[i]) * 64'(sn);
         ns_in[i]   = 34'((ns_prod[i] + 64'sh2000_0000) >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nn_ff  <= nn_in;
         ns_ff  <= ns_in;
         omc_ff <= 33'sh4000_0000 - 33'(cs);
         cs0_ff <= cs;
      end
   end

   // Symmetric part scaled by one minus cosine.
   logic signed [64:0] pm_prod [6];
   logic signed [MW-1:0] pm_ff [6];
   logic signed [33:0] ns1_ff [3];
   logic signed [31:0] cs1_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pm_prod[i] = 65'(nn_ff[i]) * 65'(omc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 6; i++) begin
            pm_ff[i] <= MW'((pm_prod[i] + 65'sh800_0000) >>> 28);
         end
         ns1_ff <= ns_ff;
         cs1_ff <= cs0_ff;
      end
   end

   // Assemble the matrix entries.
   logic signed [MW-1:0] m_in [3][3];
   logic signed [MW-1:0] m_ff [3][3];

   always_comb begin
      m_in[0][0] = pm_ff[0] + MW'(cs1_ff);
      m_in[1][1] = pm_ff[1] + MW'(cs1_ff);
      m_in[2][2] = pm_ff[2] + MW'(cs1_ff);
      m_in[0][1] = pm_ff[3] - MW'(ns1_ff[2]);
      m_in[1][0] = pm_ff[3] + MW'(ns1_ff[2]);
      m_in[0][2] = pm_ff[4] + MW'(ns1_ff[1]);
      m_in[2][0] = pm_ff[4] - MW'(ns1_ff[1]);
      m_in[1][2] = pm_ff[5] - MW'(ns1_ff[0]);
      m_in[2][1] = pm_ff[5] + MW'(ns1_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff <= m_in;
      end
   end

   // Split multiply: low coordinate bits unsigned, high bits signed.
   logic signed [VX_W-1:0] v_ext [3];
   logic signed [PL_W-1:0] pl_ff [3][3];
   logic signed [PH_W-1:0] ph_ff [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         v_ext[j] = VX_W'(vec_d_ff[VEC_DEPTH-1][j]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pl_ff[i][j] <= PL_W'(m_ff[i][j])
                  * signed'({1'b0, v_ext[j][SPLIT_BITS-1:0]});
               ph_ff[i][j] <= PH_W'(m_ff[i][j])
                  * PH_W'(signed'(v_ext[j][VX_W-1:SPLIT_BITS]));
            end
         end
      end
   end

   // Row sums.
   logic signed [SL_W-1:0] sl_ff [3];
   logic signed [SH_W-1:0] sh_ff [3];

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            sl_ff[i] <= SL_W'(pl_ff[i][0]) + SL_W'(pl_ff[i][1]) + SL_W'(pl_ff[i][2]);
            sh_ff[i] <= SH_W'(ph_ff[i][0]) + SH_W'(ph_ff[i][1]) + SH_W'(ph_ff[i][2]);
         end
      end
   end

   // Recombine, round and saturate into the result register.
   logic signed [SW-1:0]          total [3];
   logic signed [RW-1:0]          rnd_val [3];
   logic signed [COORD_WIDTH-1:0] rot_in [3];
   logic signed [COORD_WIDTH-1:0] rot_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         total[i]   = (SW'(sh_ff[i]) <<< SPLIT_BITS) + SW'(sl_ff[i])
                      + SW'(32'sh2000_0000);
         rnd_val[i] = RW'(total[i] >>> 30);
         if (rnd_val[i][RW-1:COORD_WIDTH-1] != {(RW-COORD_WIDTH+1){rnd_val[i][RW-1]}}) begin
            rot_in[i] = rnd_val[i][RW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                         : {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else begin
            rot_in[i] = rnd_val[i][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in;
      end
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_rot_x = rot_ff[0];
   assign rsp_rot_y = rot_ff[1];
   assign rsp_rot_z = rot_ff[2];

endmodule

`default_nettype wire
